FILE: design/ata_pkg.sv
// Shared types, constants and helper functions for the accelerometer tilt angle block.
package ata_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN = 24;
	localparam int CORDIC_NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
	localparam int STEP_W = $clog2(ATAN_LEN);

	localparam int RAW_W = 8;
	localparam int MAG_W = 12;
	localparam int PRESCALE = 12;
	localparam int XW = 26;
	localparam int ZW = 25;
	localparam int FRAC_W = 16;
	localparam int DEG_W = 7;
	localparam int ANGLE_W = 9;

	localparam int RIGHT_ANGLE = 90;
	localparam int HALF_TURN = 180;
	localparam int Z_MAX = RIGHT_ANGLE << FRAC_W;

	localparam logic signed [ANGLE_W-1:0] WINDOW_LOW_RST = ANGLE_W'(-135);
	localparam logic signed [ANGLE_W-1:0] WINDOW_HIGH_RST = ANGLE_W'(-45);

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LOW  = 1'b0,
		REG_WINDOW_HIGH = 1'b1
	} ata_reg_t;

	localparam logic [MAG_W-1:0] BIT_WEIGHT [7] = '{
		12'd1142, 12'd571, 12'd286, 12'd143, 12'd71, 12'd36, 12'd18
	};

	localparam logic [ZW-1:0] ATAN_Q16 [ATAN_LEN] = '{
		25'd2949120, 25'd1740967, 25'd919879, 25'd466945, 25'd234379, 25'd117304,
		25'd58666, 25'd29335, 25'd14668, 25'd7334, 25'd3667, 25'd1833,
		25'd917, 25'd458, 25'd229, 25'd115, 25'd57, 25'd29,
		25'd14, 25'd7, 25'd4, 25'd2, 25'd1, 25'd0
	};

	typedef struct packed {
		logic [RAW_W-1:0] x_raw;
		logic [RAW_W-1:0] z_raw;
	} ata_in_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_deg;
		logic                      in_window;
	} ata_out_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} ata_vec_t;

	typedef struct packed {
		logic valid;
		logic x_neg;
		logic z_neg;
		logic x_zero;
		logic z_zero;
	} ata_ctl_t;

	function automatic logic [MAG_W-1:0] decode_mag(input logic [RAW_W-1:0] raw);
		logic [MAG_W-1:0] sum;
		sum = '0;
		for (int k = 0; k < 7; k++) begin
			if (raw[6-k] != raw[7]) begin
				sum = sum + BIT_WEIGHT[k];
			end
		end
		return sum;
	endfunction

endpackage

FILE: design/ata_decode.sv
// Input decode stage: raw bytes to milli-g magnitudes and signs, CORDIC start vector.
module ata_decode import ata_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ata_in_t  sample,
	output ata_vec_t vec_s1,
	output ata_ctl_t ctl_s1
);

	logic [MAG_W-1:0] x_mag;
	logic [MAG_W-1:0] z_mag;

	always_comb begin
		x_mag = decode_mag(sample.x_raw);
		z_mag = decode_mag(sample.z_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= start;
			ctl_s1.x_neg  <= sample.x_raw[RAW_W-1] && (x_mag != '0);
			ctl_s1.z_neg  <= sample.z_raw[RAW_W-1] && (z_mag != '0);
			ctl_s1.x_zero <= (x_mag == '0);
			ctl_s1.z_zero <= (z_mag == '0);
		end
	end

	always_ff @(posedge clk) begin
		vec_s1.x <= XW'({z_mag, {PRESCALE{1'b0}}});
		vec_s1.y <= XW'({x_mag, {PRESCALE{1'b0}}});
		vec_s1.z <= '0;
	end

endmodule

FILE: design/ata_cell.sv
// One CORDIC vectoring cell: a single micro-rotation followed by a register.
module ata_cell import ata_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step,
	input  ata_vec_t          vec_in,
	input  ata_ctl_t          ctl_in,
	output ata_vec_t          vec_s1,
	output ata_ctl_t          ctl_s1
);

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	ata_vec_t             vec_nx;

	always_comb begin
		dx = vec_in.y >>> step;
		dy = vec_in.x >>> step;
		vec_nx = vec_in;
		if (vec_in.y > 0) begin
			vec_nx.x = vec_in.x + dx;
			vec_nx.y = vec_in.y - dy;
			vec_nx.z = vec_in.z + $signed(ATAN_Q16[step]);
		end else if (vec_in.y < 0) begin
			vec_nx.x = vec_in.x - dx;
			vec_nx.y = vec_in.y + dy;
			vec_nx.z = vec_in.z - $signed(ATAN_Q16[step]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= vec_nx;
	end

	// The X component starts non-negative and only grows in vectoring mode.
	a_x_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid |-> !vec_s1.x[XW-1])
		else $error("CORDIC X component went negative");

endmodule

FILE: design/ata_out.sv
// Output stage: angle clamp, quadrant correction, window registers and compare.
module ata_out import ata_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ata_vec_t             vec_in,
	input  ata_ctl_t             ctl_in,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [ANGLE_W-1:0]   cfg_wdata,
	output logic                 done,
	output ata_out_t             result
);

	logic signed [ANGLE_W-1:0] window_low_q;
	logic signed [ANGLE_W-1:0] window_high_q;
	logic [DEG_W-1:0]          mag;
	logic signed [ANGLE_W:0]   a_w;
	logic signed [ANGLE_W:0]   ang_w;
	logic signed [ANGLE_W-1:0] angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= WINDOW_LOW_RST;
			window_high_q <= WINDOW_HIGH_RST;
		end else if (cfg_we) begin
			case (ata_reg_t'(cfg_idx))
				REG_WINDOW_LOW:  window_low_q  <= cfg_wdata;
				REG_WINDOW_HIGH: window_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (vec_in.z < 0) begin
			mag = '0;
		end else if (vec_in.z > ZW'(Z_MAX)) begin
			mag = DEG_W'(RIGHT_ANGLE);
		end else begin
			mag = vec_in.z[FRAC_W+DEG_W-1:FRAC_W];
		end

		if (ctl_in.x_neg == ctl_in.z_neg) begin
			a_w = (ANGLE_W+1)'(signed'({1'b0, mag}));
		end else begin
			a_w = -((ANGLE_W+1)'(signed'({1'b0, mag})));
		end

		if (ctl_in.z_zero) begin
			if (ctl_in.x_zero) begin
				ang_w = '0;
			end else if (ctl_in.x_neg) begin
				ang_w = (ANGLE_W+1)'(RIGHT_ANGLE);
			end else begin
				ang_w = (ANGLE_W+1)'(-RIGHT_ANGLE);
			end
		end else if (!ctl_in.x_neg && ctl_in.z_neg) begin
			ang_w = (ANGLE_W+1)'(-HALF_TURN) - a_w;
		end else if (ctl_in.x_neg && ctl_in.z_neg) begin
			ang_w = (ANGLE_W+1)'(HALF_TURN) - a_w;
		end else begin
			ang_w = -a_w;
		end
		angle = ang_w[ANGLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		result.angle_deg <= angle;
		result.in_window <= (angle >= window_low_q) && (angle <= window_high_q);
	end

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.angle_deg >= ANGLE_W'(-HALF_TURN))
			&& (result.angle_deg <= ANGLE_W'(HALF_TURN)))
		else $error("Angle outside the half-turn range");

	a_window_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.in_window) |-> (result.angle_deg >= window_low_q)
			&& (result.angle_deg <= window_high_q))
		else $error("Window flag set for an angle outside the window");

endmodule

FILE: design/accel_tilt_angle.sv
// Top level of the accelerometer tilt angle block: decode, CORDIC cell chain, output stage.
//
//  Channel  | Ports                          | Transfer when
//  ---------+--------------------------------+------------------------------
//  Input    | start, busy, sample            | start high and busy low
//  Result   | done, result                   | done high (one cycle, no stall)
//  Config   | cfg_we, cfg_idx, cfg_wdata     | cfg_we high
//
// One sample pair is taken every cycle; busy stays low.
// A result reaches the result ports through the decode register, which loads at the input
// transfer edge, one register in each CORDIC cell and one in the output stage, and
// transfers at the following edge.
// Reset clears all valid flags and loads the window registers to -135 and -45.
// The receiver cannot stall, so the pipeline always advances.
module accel_tilt_angle import ata_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ata_in_t              sample,
	output logic                 done,
	output ata_out_t             result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [ANGLE_W-1:0]   cfg_wdata
);

	ata_vec_t vec [CORDIC_NSTEPS+1];
	ata_ctl_t ctl [CORDIC_NSTEPS+1];

	assign busy = 1'b0;

	ata_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sample (sample),
		.vec_s1 (vec[0]),
		.ctl_s1 (ctl[0])
	);

	for (genvar i = 0; i < CORDIC_NSTEPS; i++) begin : g_cell
		ata_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (STEP_W'(i)),
			.vec_in (vec[i]),
			.ctl_in (ctl[i]),
			.vec_s1 (vec[i+1]),
			.ctl_s1 (ctl[i+1])
		);
	end

	ata_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec_in    (vec[CORDIC_NSTEPS]),
		.ctl_in    (ctl[CORDIC_NSTEPS]),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	a_chain_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl[CORDIC_NSTEPS].valid |=> done)
		else $error("Item at the end of the cell chain produced no result");

	a_done_from_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl[CORDIC_NSTEPS].valid |=> !done)
		else $error("Result strobe without an item at the end of the cell chain");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the accelerometer tilt angle block with a CORDIC-based predictor.
module testbench;
	import ata_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROT_STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int N_WINDOWS = 10;
	localparam int ITEMS_PER_WINDOW = 194;

	localparam int TAN_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};
	localparam int MG_WEIGHT [7] = '{1142, 571, 286, 143, 71, 36, 18};
	localparam logic [RAW_W-1:0] EDGE_BYTES [4] = '{8'h00, 8'hFF, 8'h7F, 8'h80};

	typedef enum logic {ACT_SAMPLE, ACT_WRITE} act_kind_t;

	typedef struct {
		act_kind_t            kind;
		ata_in_t              smp;
		ata_reg_t             idx;
		logic [ANGLE_W-1:0]   wdata;
	} stim_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	ata_in_t              sample = '0;
	logic                 done;
	ata_out_t             result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [ANGLE_W-1:0]   cfg_wdata = '0;

	stim_t    stim_q[$];
	ata_out_t tilt_q[$];
	int       mismatches = 0;

	logic signed [ANGLE_W-1:0] win_lo = WINDOW_LOW_RST;
	logic signed [ANGLE_W-1:0] win_hi = WINDOW_HIGH_RST;

	accel_tilt_angle dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int decode_mg(logic [RAW_W-1:0] raw);
		int sum;
		sum = 0;
		for (int k = 0; k < 7; k++) begin
			if (raw[6-k] != raw[7]) begin
				sum += MG_WEIGHT[k];
			end
		end
		return raw[7] ? -sum : sum;
	endfunction

	function automatic int atan_mag_deg(int nx, int ny);
		int cx, cy, cz, dx, dy;
		cx = nx <<< 12;
		cy = ny <<< 12;
		cz = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy > 0) begin
				cx += dx;
				cy -= dy;
				cz += TAN_Q16[i];
			end else if (cy < 0) begin
				cx -= dx;
				cy += dy;
				cz -= TAN_Q16[i];
			end
		end
		if (cz < 0) cz = 0;
		if (cz > 90 * 65536) cz = 90 * 65536;
		return cz >>> 16;
	endfunction

	function automatic ata_out_t predict_tilt(ata_in_t s, logic signed [ANGLE_W-1:0] lo,
			logic signed [ANGLE_W-1:0] hi);
		int x, z, a, m, ang;
		ata_out_t r;
		x = decode_mg(s.x_raw);
		z = decode_mg(s.z_raw);
		if (z == 0) begin
			a = (x > 0) ? 90 : ((x < 0) ? -90 : 0);
		end else begin
			m = atan_mag_deg((z < 0) ? -z : z, (x < 0) ? -x : x);
			a = ((x < 0) == (z < 0)) ? m : -m;
		end
		if (x == 0 && z == 0) ang = 0;
		else if (x >= 0 && z < 0) ang = -180 - a;
		else if (x < 0 && z < 0) ang = 180 - a;
		else ang = -a;
		r.angle_deg = ang[ANGLE_W-1:0];
		r.in_window = (ang >= lo && ang <= hi);
		return r;
	endfunction

	task automatic add_sample(logic [RAW_W-1:0] x, logic [RAW_W-1:0] z);
		stim_t s;
		s.kind = ACT_SAMPLE;
		s.smp.x_raw = x;
		s.smp.z_raw = z;
		s.idx = REG_WINDOW_LOW;
		s.wdata = '0;
		stim_q.push_back(s);
	endtask

	task automatic add_write(ata_reg_t idx, logic [ANGLE_W-1:0] v);
		stim_t s;
		s.kind = ACT_WRITE;
		s.smp = '0;
		s.idx = idx;
		s.wdata = v;
		stim_q.push_back(s);
	endtask

	// Driver: samples are presented back to back or after a random gap; register writes wait
	// until every outstanding result has come back.
	int   gap = 0;
	bit   steady = 1'b0;
	logic took, nxt_start, nxt_we;
	int   r;

	always @(posedge clk) begin
		if (arst_n) begin
			took = start && !busy;
			if (took) begin
				tilt_q.push_back(predict_tilt(sample, win_lo, win_hi));
				if ($urandom_range(0, 149) == 0) steady = !steady;
				if (!steady) begin
					r = $urandom_range(0, 99);
					if (r < 55) gap = 0;
					else if (r < 85) gap = $urandom_range(1, 3);
					else if (r < 97) gap = $urandom_range(4, 15);
					else gap = $urandom_range(20, 60);
				end
			end
			nxt_start = start && !took;
			nxt_we = 1'b0;
			if (!nxt_start && gap > 0) begin
				gap--;
			end else if (!nxt_start && stim_q.size() > 0) begin
				if (stim_q[0].kind == ACT_SAMPLE) begin
					nxt_start = 1'b1;
					sample <= stim_q[0].smp;
					void'(stim_q.pop_front());
				end else if (!took && !start && tilt_q.size() == 0) begin
					nxt_we = 1'b1;
					cfg_idx <= stim_q[0].idx;
					cfg_wdata <= stim_q[0].wdata;
					if (stim_q[0].idx == REG_WINDOW_LOW) win_lo = stim_q[0].wdata;
					else win_hi = stim_q[0].wdata;
					void'(stim_q.pop_front());
				end
			end
			start <= nxt_start;
			cfg_we <= nxt_we;
		end
	end

	// Monitor: every result transfer is checked against the oldest prediction.
	ata_out_t want;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (tilt_q.size() == 0) begin
				if (mismatches < 10) $display("Result with no expectation: angle %0d flag %0b",
					result.angle_deg, result.in_window);
				mismatches++;
			end else begin
				want = tilt_q.pop_front();
				if (result.angle_deg !== want.angle_deg) begin
					if (mismatches < 10) $display("angle_deg mismatch: expected %0d, actual %0d",
						want.angle_deg, result.angle_deg);
					mismatches++;
				end
				if (result.in_window !== want.in_window) begin
					if (mismatches < 10) $display("in_window mismatch: expected %0b, actual %0b",
						want.in_window, result.in_window);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic [ANGLE_W-1:0] lo_set [N_WINDOWS];
		logic [ANGLE_W-1:0] hi_set [N_WINDOWS];
		logic [RAW_W-1:0]   x, z;

		lo_set = '{-9'sd180, 9'sd0, 9'sd180, 9'h100, -9'sd90, 9'sd45, -9'sd1, 9'h0, 9'h0, 9'h0};
		hi_set = '{9'sd180, 9'sd0, -9'sd180, 9'h0FF, 9'sd90, 9'sd135, -9'sd1, 9'h0, 9'h0, 9'h0};
		for (int w = 7; w < N_WINDOWS; w++) begin
			lo_set[w] = ANGLE_W'($urandom_range(0, 511));
			hi_set[w] = ANGLE_W'($urandom_range(0, 511));
		end

		add_sample(8'h00, 8'h00);
		add_sample(8'hFF, 8'hFF);
		add_sample(8'h00, 8'hFF);
		add_sample(8'h7F, 8'h00);
		add_sample(8'h80, 8'h00);
		add_sample(8'h7F, 8'hFF);
		add_sample(8'h80, 8'hFF);
		add_sample(8'h00, 8'h7F);
		add_sample(8'h00, 8'h80);
		add_sample(8'h7F, 8'h7F);
		add_sample(8'h80, 8'h80);
		add_sample(8'h7F, 8'h80);
		add_sample(8'h80, 8'h7F);
		add_sample(8'h01, 8'h7F);
		add_sample(8'h7F, 8'h01);
		add_sample(8'hFE, 8'h80);
		add_sample(8'h80, 8'hFE);
		add_sample(8'h40, 8'h40);
		add_sample(8'hC0, 8'h40);
		add_sample(8'h55, 8'hAA);
		add_sample(8'hAA, 8'h55);
		add_sample(8'h01, 8'h01);

		for (int w = 0; w < N_WINDOWS; w++) begin
			add_write(REG_WINDOW_LOW, lo_set[w]);
			add_write(REG_WINDOW_HIGH, hi_set[w]);
			for (int n = 0; n < ITEMS_PER_WINDOW; n++) begin
				x = ($urandom_range(0, 99) < 12) ? EDGE_BYTES[$urandom_range(0, 3)]
					: 8'($urandom_range(0, 255));
				z = ($urandom_range(0, 99) < 12) ? EDGE_BYTES[$urandom_range(0, 3)]
					: 8'($urandom_range(0, 255));
				add_sample(x, z);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() > 0 || start || tilt_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (tilt_q.size() > 0) mismatches++;

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
design/ata_pkg.sv
design/ata_decode.sv
design/ata_cell.sv
design/ata_out.sv
design/accel_tilt_angle.sv
dv/testbench.sv
